// ===== rtl/olee_pkg.sv =====
// Package with the shared types and command codes of the ordered list edit engine.
package olee_pkg;

    // Command codes carried on the command field of an input transaction.
    localparam logic [1:0] CMD_INSERT_FRONT = 2'd0;
    localparam logic [1:0] CMD_APPEND_BACK  = 2'd1;
    localparam logic [1:0] CMD_DELETE_AT    = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EDIT,
        S_LIST,
        S_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;   // capture the input transaction
        logic edit;    // apply the edit to the list
        logic issue;   // launch the next entry of the listing
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic can_issue;   // the read stage can take a new entry this cycle
        logic last_issue;  // the entry at the listing index is the final one
        logic s1_busy;     // the read stage still holds an entry
    } t_dp_status;

endpackage

// ===== rtl/olee_controller.sv =====
// Controller state machine that sequences the edit and the listing of each command.
module olee_controller (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output olee_pkg::t_ctrl_cmd    o_cmd,
    input  olee_pkg::t_dp_status   i_status
);

    olee_pkg::t_state r_state;
    olee_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olee_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            olee_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = olee_pkg::S_EDIT;
                end
            end
            olee_pkg::S_EDIT: begin
                o_cmd.edit = 1'b1;
                n_state    = olee_pkg::S_LIST;
            end
            olee_pkg::S_LIST: begin
                if (i_status.can_issue) begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_issue) begin
                        n_state = olee_pkg::S_DRAIN;
                    end
                end
            end
            olee_pkg::S_DRAIN: begin
                // Wait until any pending shift write has landed in the store.
                if (!i_status.s1_busy) begin
                    n_state = olee_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olee_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/olee_datapath.sv =====
// Datapath with the entry store, head pointer, entry count, read stage and output register.
module olee_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  olee_pkg::t_ctrl_cmd    i_cmd,
    output olee_pkg::t_dp_status   o_status,
    input  logic [1:0]             i_command,
    input  logic signed [63:0]     i_item_value,
    input  logic [7:0]             i_position,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic signed [63:0]     o_element_value,
    output logic                   o_last_element,
    output logic                   o_list_empty,
    output logic                   o_insert_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    // Map a logical list index onto a slot of the circular store.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] li);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(li);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // Entry store and its registered read data.
    logic [63:0]          r_mem [CAPACITY];
    logic [63:0]          r_rd_data;

    // List control state.
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;

    // Captured transaction and per-command edit results.
    logic [1:0]           r_cmd;
    logic [63:0]          r_val;
    logic [7:0]           r_pos;
    logic                 r_dropped;
    logic                 r_del;
    logic [CW-1:0]        r_del_pos;
    logic [CW-1:0]        r_idx;

    // Read stage.
    logic                 r_s1_vld;
    logic                 r_s1_last;
    logic                 r_s1_empty;
    logic                 r_s1_wr;
    logic [AW-1:0]        r_s1_wr_addr;

    // Output register.
    logic                 r_out_vld;
    logic [63:0]          r_out_value;
    logic                 r_out_last;
    logic                 r_out_empty;
    logic                 r_out_dropped;

    logic                 w_full;
    logic                 w_is_insert;
    logic [AW-1:0]        w_head_dec;
    logic                 w_del_ok;
    logic                 w_empty;
    logic                 w_shift;
    logic [CW-1:0]        w_rd_li;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_shift_addr;
    logic                 w_last;
    logic                 w_adv;
    logic                 w_rd_en;
    logic                 w_edit_we;
    logic [AW-1:0]        w_edit_addr;
    logic                 w_shift_we;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic [63:0]          w_mem_wdata;

    // Edit decode.
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_is_insert = (r_cmd == olee_pkg::CMD_INSERT_FRONT) ||
                         (r_cmd == olee_pkg::CMD_APPEND_BACK);
    assign w_head_dec  = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign w_del_ok    = (8'(r_count) > r_pos);
    assign w_edit_we   = i_cmd.edit && w_is_insert && !w_full;
    assign w_edit_addr = (r_cmd == olee_pkg::CMD_INSERT_FRONT) ? w_head_dec
                                                               : f_phys(r_head, r_count);

    // Listing addresses. After a delete, entries from the deleted position on are
    // read one slot further back and written one slot forward as they are listed.
    assign w_empty      = (r_count == '0);
    assign w_shift      = r_del && (r_idx >= r_del_pos);
    assign w_rd_li      = w_shift ? r_idx + CW'(1) : r_idx;
    assign w_rd_addr    = f_phys(r_head, w_rd_li);
    assign w_shift_addr = f_phys(r_head, r_idx);
    assign w_last       = w_empty || (r_idx + CW'(1) == r_count);
    assign w_adv        = !r_out_vld || !i_out_stall;
    assign w_rd_en      = i_cmd.issue && !w_empty;

    // Single write port shared by the edit write and the shift write.
    assign w_shift_we  = r_s1_vld && w_adv && r_s1_wr;
    assign w_mem_we    = w_edit_we || w_shift_we;
    assign w_mem_waddr = w_shift_we ? r_s1_wr_addr : w_edit_addr;
    assign w_mem_wdata = w_shift_we ? r_rd_data : r_val;

    // Status to the controller.
    assign o_status.can_issue  = !r_s1_vld || w_adv;
    assign o_status.last_issue = w_last;
    assign o_status.s1_busy    = r_s1_vld;

    // Entry store.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Head pointer and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.edit) begin
            case (r_cmd)
                olee_pkg::CMD_INSERT_FRONT: begin
                    if (!w_full) begin
                        r_head  <= w_head_dec;
                        r_count <= r_count + CW'(1);
                    end
                end
                olee_pkg::CMD_APPEND_BACK: begin
                    if (!w_full) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                olee_pkg::CMD_DELETE_AT: begin
                    if (w_del_ok) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Transaction capture, edit results and listing index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_val <= $unsigned(i_item_value);
            r_pos <= i_position;
        end
        if (i_cmd.edit) begin
            r_dropped <= w_is_insert && w_full;
            r_del     <= (r_cmd == olee_pkg::CMD_DELETE_AT) && w_del_ok;
            r_del_pos <= CW'(r_pos);
            r_idx     <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // Read stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_cmd.issue) begin
            r_s1_vld <= 1'b1;
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Read stage payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_last    <= w_last;
            r_s1_empty   <= w_empty;
            r_s1_wr      <= w_shift && !w_empty;
            r_s1_wr_addr <= w_shift_addr;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_vld) begin
            r_out_value   <= r_s1_empty ? '0 : r_rd_data;
            r_out_last    <= r_s1_last;
            r_out_empty   <= r_s1_empty;
            r_out_dropped <= r_dropped;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_element_value  = $signed(r_out_value);
    assign o_last_element   = r_out_last;
    assign o_list_empty     = r_out_empty;
    assign o_insert_dropped = r_out_dropped;

endmodule

// ===== rtl/ordered_list_edit_engine_top.sv =====
// Top level of the ordered list edit engine: controller, datapath and checks.
//
// Keeps an ordered list of up to CAPACITY signed 64-bit entries. Each input
// transaction carries a command: insert at the front, append at the back, or
// delete at a zero-based position. After the edit the full list is sent out
// front to back as one output transaction per entry, the final one marked by
// o_last_element; an empty list gives a single transaction with o_list_empty.
// An insert into a full list leaves the list unchanged and sets
// o_insert_dropped on every transaction of that listing.
// Both channels use valid and stall; a transaction moves on a rising edge with
// valid high and stall low. After a command is taken the edit is applied, then
// each entry passes through the read stage and the output register, one per
// cycle while the output is not stalled. The next command is taken only after
// the edit, the reading of every entry and the retiring of the last read from
// the read stage. The store has one read and one write port, which sets the
// one-entry-per-cycle listing; a delete closes the gap while the list is read.
// While the output is stalled the listing pauses and holds its last result.
// Reset empties the list at once; store contents are never read before written.
module ordered_list_edit_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic signed [63:0] i_item_value,
    input  logic [7:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_element_value,
    output logic               o_last_element,
    output logic               o_list_empty,
    output logic               o_insert_dropped
);

    olee_pkg::t_ctrl_cmd  w_cmd;
    olee_pkg::t_dp_status w_status;

    // Sequencing of the edit and the listing.
    olee_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // Store, list state and output stage.
    olee_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_command        (i_command),
        .i_item_value     (i_item_value),
        .i_position       (i_position),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_element_value  (o_element_value),
        .o_last_element   (o_last_element),
        .o_list_empty     (o_list_empty),
        .o_insert_dropped (o_insert_dropped)
    );

`ifndef NO_ASSERTIONS
    // A taken command blocks the input until the last entry of its listing has left the read stage.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a command was taken");

    // An entry is launched only when the read stage has room for it.
    a_issue_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> w_status.can_issue)
        else $error("entry launched into a full read stage");

    // An empty listing is always a single, final transaction.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_list_empty) |-> o_last_element)
        else $error("empty listing not marked as last");
`endif

endmodule
